@@ sv/cfps_pkg.sv @@
// ----------------------------------------------------------------------------
// cfps_pkg
// Shared types and constants of the congestion feedback port statistics block.
// ----------------------------------------------------------------------------
package cfps_pkg;

  localparam int unsigned SUM_W = 48;
  localparam int unsigned CAP_W = 40;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [2:0] REG_SENDS = 3'd4;

  typedef struct packed {
    logic        op;
    logic [1:0]  port;
    logic [7:0]  hop_current;
    logic [7:0]  hop_target;
    logic [7:0]  hop_suggested;
    logic [15:0] overload_in;
    logic [31:0] fair_in;
    logic [31:0] flow_rate;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  hop_current_out;
    logic [7:0]  hop_suggested_out;
    logic [15:0] overload_out;
    logic [31:0] fair_out;
    logic [31:0] iteration_out;
    logic        replaced;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic probe;      // run one probe update, load output register
    logic tick_start; // latch operands of the current tick port
    logic div_start;  // start both dividers
    logic tick_write; // write back tick results of the current port
    logic port_next;  // advance tick port
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic last_port;
  } status_t;

endpackage

@@ sv/cfps_div.sv @@
// ----------------------------------------------------------------------------
// cfps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfps_div import cfps_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;

  // Shift one dividend bit into the remainder and try a subtract
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      // Flag done once the last quotient bit is registered
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

@@ sv/cfps_datapath.sv @@
// ----------------------------------------------------------------------------
// cfps_datapath
// Per-port statistics registers, probe update and tick arithmetic.
// ----------------------------------------------------------------------------
module cfps_datapath import cfps_pkg::*; #(
  parameter int unsigned PORTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  in_item_t    item,
  input  cmd_t        cmd,
  output status_t     status,
  output out_item_t   result
);

  localparam int unsigned PW = (PORTS > 1) ? $clog2(PORTS) : 1;

  logic [31:0]      rate_r [4];
  logic [7:0]       sends_r;
  logic [31:0]      flow_r [PORTS];
  logic [SUM_W-1:0] unc_r  [PORTS];
  logic [SUM_W-1:0] tot_r  [PORTS];
  logic [15:0]      ovl_r  [PORTS];
  logic [31:0]      fair_r [PORTS];
  logic [31:0]      iter_r [PORTS];
  logic [PORTS-1:0] ticked_r;
  logic [PW-1:0]    tp_r;
  out_item_t        result_r;

  // Tick operands
  logic [CAP_W-1:0] cap_r;
  logic [SUM_W-1:0] y_r;
  logic             ovl_zero_r;
  logic [1:0]       fair_sel_r;  // 0 divide, 1 line rate, 2 zero
  logic [63:0]      ovl_q, fair_q;
  logic             ovl_done, fair_done;
  logic [63:0]      ovl_num, fair_num;
  logic [31:0]      flow_div_r;

  logic [7:0]        s_eff;
  logic [CAP_W-1:0]  cap_cur;
  logic [SUM_W-1:0]  u_cur, y_cur;
  logic [31:0]       f_cur;
  logic [1:0]        ip;
  logic [PW-1:0]     pp;
  logic [7:0]        hc;
  logic [15:0]       p_ov;
  logic [31:0]       p_fair;
  logic              rep;
  logic [SUM_W:0]    unc_sum, tot_sum;

  assign s_eff   = (sends_r == 8'd0) ? 8'd1 : sends_r;
  assign ip      = 2'(tp_r);
  assign cap_cur = CAP_W'(rate_r[ip]) * CAP_W'(s_eff);
  assign u_cur   = unc_r[tp_r];
  assign y_cur   = tot_r[tp_r];
  assign f_cur   = flow_r[tp_r];

  // Probe comparison against the addressed port
  assign pp     = PW'(item.port);
  assign hc     = item.hop_current + 8'd1;
  assign p_ov   = ovl_r[pp];
  assign p_fair = ticked_r[pp] ? fair_r[pp] : rate_r[item.port];
  assign rep    = (p_ov > item.overload_in) ||
                  ((p_ov == item.overload_in) && (p_fair < item.fair_in));
  assign unc_sum = {1'b0, unc_r[pp]} + (SUM_W+1)'(item.flow_rate);
  assign tot_sum = {1'b0, tot_r[pp]} + (SUM_W+1)'(item.flow_rate);

  assign ovl_num = {(y_r - SUM_W'(cap_r)), 16'd0};
  assign fair_num = 64'(SUM_W'(cap_r) - u_cur);

  cfps_div #(.W(64)) u_div_ovl (
    .clk, .rst_n, .start(cmd.div_start), .dividend(ovl_num),
    .divisor(64'(y_r)), .quotient(ovl_q), .done(ovl_done)
  );

  cfps_div #(.W(64)) u_div_fair (
    .clk, .rst_n, .start(cmd.div_start), .dividend(fair_num),
    .divisor(64'(flow_div_r)), .quotient(fair_q), .done(fair_done)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) rate_r[i] <= '0;
      sends_r <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index < REG_SENDS) rate_r[cfg_index[1:0]] <= cfg_wdata;
      else if (cfg_index == REG_SENDS) sends_r <= cfg_wdata[7:0];
    end
  end

  // Statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        flow_r[i] <= '0;
        unc_r[i]  <= '0;
        tot_r[i]  <= '0;
        ovl_r[i]  <= '0;
        fair_r[i] <= '0;
        iter_r[i] <= '0;
      end
      ticked_r <= '0;
      tp_r     <= '0;
    end else begin
      if (cmd.probe && (32'(item.port) < PORTS)) begin
        if (hc == item.hop_target) begin
          if (flow_r[pp] != '1) flow_r[pp] <= flow_r[pp] + 32'd1;
        end else begin
          unc_r[pp] <= unc_sum[SUM_W] ? '1 : unc_sum[SUM_W-1:0];
        end
        tot_r[pp] <= tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
      end
      if (cmd.tick_write) begin
        ovl_r[tp_r]    <= ovl_zero_r ? 16'd0 : ovl_q[15:0];
        unique case (fair_sel_r)
          2'd1:    fair_r[tp_r] <= rate_r[ip];
          2'd2:    fair_r[tp_r] <= '0;
          default: fair_r[tp_r] <= fair_q[31:0];
        endcase
        ticked_r[tp_r] <= 1'b1;
        flow_r[tp_r]   <= '0;
        unc_r[tp_r]    <= '0;
        tot_r[tp_r]    <= '0;
        iter_r[tp_r]   <= iter_r[tp_r] + 32'd1;
      end
      if (cmd.port_next)
        tp_r <= status.last_port ? '0 : tp_r + 1'b1;
    end
  end

  // Latch tick operands of the current port
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      cap_r      <= cap_cur;
      y_r        <= y_cur;
      flow_div_r <= (f_cur == '0) ? 32'd1 : f_cur;
      ovl_zero_r <= (y_cur <= SUM_W'(cap_cur));
      if (f_cur < 32'(s_eff))          fair_sel_r <= 2'd1;
      else if (u_cur >= SUM_W'(cap_cur)) fair_sel_r <= 2'd2;
      else                             fair_sel_r <= 2'd0;
    end
  end

  // Hold the probe result
  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      result_r.hop_current_out   <= hc;
      result_r.hop_suggested_out <= rep ? hc : item.hop_suggested;
      result_r.overload_out      <= rep ? p_ov : item.overload_in;
      result_r.fair_out          <= rep ? p_fair : item.fair_in;
      result_r.iteration_out     <= iter_r[pp];
      result_r.replaced          <= rep;
    end
  end

  assign result           = result_r;
  assign status.div_done  = ovl_done && fair_done;
  assign status.last_port = (32'(tp_r) == PORTS - 1);

endmodule

@@ sv/cfps_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfps_ctrl
// Controller: probe handshake, tick sequencing over ports, output valid.
// ----------------------------------------------------------------------------
module cfps_ctrl import cfps_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_op,
  input  logic    in_port_ok,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  // Accept while idle and the result slot is free or leaving
  assign in_stall = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == OP_TICK) state_nxt = ST_LOAD;
          else begin
            cmd.probe = 1'b1;
            if (in_port_ok) ov_nxt = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.tick_start = 1'b1;
        state_nxt      = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      default: begin
        if (status.div_done) begin
          cmd.tick_write = 1'b1;
          cmd.port_next  = 1'b1;
          state_nxt      = status.last_port ? ST_IDLE : ST_LOAD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule

@@ sv/congestion_feedback_port_stats.sv @@
// ----------------------------------------------------------------------------
// congestion_feedback_port_stats
// Per-output-port congestion statistics for explicit-rate feedback probes.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries probes and collection ticks.
// A probe reads and updates its port's entry, and its result sits in the
// output register the next cycle; probes stream at one per cycle while
// out_stall is low. A probe to a port at or beyond PORTS is consumed with no
// result. A tick produces no result; it walks the ports one after another
// through two 64-step restoring dividers (overload and fair rate), each port
// passing through the load, start and divide states. in_stall is high during
// a tick. When the receiver stalls, the result holds on out_data and a new
// item is taken only as the slot frees. Configuration is written on cfg_we
// with cfg_index/cfg_wdata, in idle only by the user; the block does not check.
// Synchronous reset clears all statistics, line rates to 0, multiplier to 1.
// ----------------------------------------------------------------------------
module congestion_feedback_port_stats import cfps_pkg::*; #(
  parameter int unsigned PORTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  cfps_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op(in_data.op),
    .in_port_ok(32'(in_data.port) < PORTS),
    .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  cfps_datapath #(.PORTS(PORTS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .item(in_data), .cmd, .status, .result(out_data)
  );

  // A tick holds off the input channel
  a_tick_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_TICK) |=> in_stall)
    else $error("input accepted during tick");

  // A pending stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A tick never raises a result
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_write |-> !cmd.probe)
    else $error("probe during tick write");

endmodule

@@ sim/tb_congestion_feedback_port_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_congestion_feedback_port_stats
// Self-checking bench: directed probes and ticks, then random traffic under
// several idle and stall mixes; every result is compared against a port
// statistics predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_congestion_feedback_port_stats;
  import cfps_pkg::*;

  localparam int NPORTS = 4;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [2:0] REG_RATE0 = 3'd0;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor state
  logic [31:0] rate_m [NPORTS];
  logic [7:0]  mult_reg;
  logic [31:0] flows [NPORTS];
  logic [47:0] uncon [NPORTS];
  logic [47:0] total [NPORTS];
  logic [15:0] ovl [NPORTS];
  logic [31:0] fair [NPORTS];
  logic [31:0] iter [NPORTS];
  logic        ticked [NPORTS];

  out_item_t   expected_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;
  int          quiet = 0;
  int          hop_bias = 50;

  congestion_feedback_port_stats dut (.*);

  always #5 clk = ~clk;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // apply a register write to the predictor
  task automatic model_cfg(input logic [2:0] idx, input logic [31:0] val);
    if (idx < REG_SENDS) rate_m[idx[1:0]] = val;
    else if (idx == REG_SENDS) mult_reg = val[7:0];
  endtask

  task automatic model_tick();
    logic [63:0] s, cap, y, u;
    for (int p = 0; p < NPORTS; p++) begin
      s = (mult_reg == 0) ? 64'd1 : 64'(mult_reg);
      cap = 64'(rate_m[p]) * s;
      y = 64'(total[p]);
      u = 64'(uncon[p]);
      if (y <= cap) ovl[p] = '0;
      else ovl[p] = 16'(((y - cap) << 16) / y);
      if (64'(flows[p]) < s) fair[p] = rate_m[p];
      else if (u >= cap) fair[p] = '0;
      else fair[p] = 32'((cap - u) / 64'(flows[p]));
      ticked[p] = 1'b1;
      flows[p] = '0;
      uncon[p] = '0;
      total[p] = '0;
      iter[p] = iter[p] + 1;
    end
  endtask

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? SUM_SAT : s[47:0];
  endfunction

  // work out the result of one probe and update its port
  task automatic model_probe(input in_item_t it);
    out_item_t r;
    logic [31:0] pf;
    int p;
    p = it.port;
    r.hop_current_out = it.hop_current + 8'd1;
    pf = ticked[p] ? fair[p] : rate_m[p];
    r.replaced = (ovl[p] > it.overload_in) || (ovl[p] == it.overload_in && pf < it.fair_in);
    r.hop_suggested_out = r.replaced ? r.hop_current_out : it.hop_suggested;
    r.overload_out = r.replaced ? ovl[p] : it.overload_in;
    r.fair_out = r.replaced ? pf : it.fair_in;
    r.iteration_out = iter[p];
    if (r.hop_current_out == it.hop_target) begin
      if (flows[p] != 32'hFFFF_FFFF) flows[p] = flows[p] + 1;
    end else begin
      uncon[p] = sat_add(uncon[p], it.flow_rate);
    end
    total[p] = sat_add(total[p], it.flow_rate);
    r.iteration_out = iter[p];
    expected_q.push_back(r);
  endtask

  // send one transaction, hold until accepted; valid stays up for a follower
  task automatic send(input in_item_t it);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_TICK) model_tick();
    else model_probe(it);
    @(negedge clk);
  endtask

  // drop valid once no transaction follows
  task automatic idle_in();
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    model_cfg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for all results, then let a tick in progress finish
  task automatic drain();
    idle_in();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic in_item_t rand_probe();
    in_item_t it;
    it.op = OP_PROBE;
    it.port = 2'($urandom_range(3, 0));
    it.hop_current = 8'($urandom);
    it.hop_target = ($urandom_range(99, 0) < hop_bias) ? it.hop_current + 8'd1 : 8'($urandom);
    it.hop_suggested = 8'($urandom);
    case ($urandom_range(3, 0))
      0: it.overload_in = '0;
      1: it.overload_in = 16'hFFFF;
      default: it.overload_in = 16'($urandom);
    endcase
    it.fair_in = ($urandom_range(3, 0) == 0) ? 32'($urandom_range(2000, 0)) : $urandom;
    case ($urandom_range(3, 0))
      0: it.flow_rate = 32'hFFFF_FFFF;
      1: it.flow_rate = $urandom_range(1000, 0);
      default: it.flow_rate = $urandom;
    endcase
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it = '0;
    it.op = OP_TICK;
    it.port = 2'($urandom);
    it.flow_rate = $urandom;
    return it;
  endfunction

  task automatic random_cfg(input bit extremes);
    for (int p = 0; p < NPORTS; p++)
      write_reg(REG_RATE0 + 3'(p), extremes ? (p[0] ? 32'hFFFF_FFFF : 32'd0)
                                            : 32'($urandom_range(100000, 0)) << $urandom_range(12, 0));
    write_reg(REG_SENDS, extremes ? 32'd255 : 32'($urandom_range(255, 0)));
  endtask

  task automatic test_directed();
    in_item_t it;
    random_cfg(1'b1);
    // extremes of every field, with matching and missing target hops
    for (int i = 0; i < 8; i++) begin
      it = '0;
      it.port = 2'(i);
      it.hop_current = i[0] ? 8'hFF : 8'h00;
      it.hop_target = i[1] ? it.hop_current + 8'd1 : 8'h55;
      it.hop_suggested = i[2] ? 8'hFF : 8'h00;
      it.overload_in = i[0] ? 16'hFFFF : 16'h0000;
      it.fair_in = i[1] ? 32'hFFFF_FFFF : 32'd0;
      it.flow_rate = 32'hFFFF_FFFF;
      send(it);
    end
    send(tick_item());
    // equal overloads: replacement decided by fair rate
    for (int i = 0; i < 4; i++) begin
      it = '0;
      it.port = 2'(i);
      it.fair_in = i[0] ? 32'hFFFF_FFFF : 32'd0;
      it.flow_rate = 32'd7;
      it.hop_target = 8'd1;
      send(it);
    end
    drain();
    write_reg(REG_SENDS, 32'd0);
    write_reg(REG_NONE, 32'hDEAD_BEEF);
    send(tick_item());
    for (int i = 0; i < 4; i++) send(rand_probe());
    send(tick_item());
    drain();
  endtask

  task automatic test_random(input int items, input int ip, input int sp);
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(39, 0) == 0) send(tick_item());
      else send(rand_probe());
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 60; i++) send(rand_probe());
    idle_in();
    while (hold_off > 0) @(negedge clk);
    drain();
    // pause until everything is back, then resume
    for (int i = 0; i < 20; i++) send(rand_probe());
    idle_in();
    while (expected_q.size() != 0) @(negedge clk);
    for (int i = 0; i < 20; i++) send(rand_probe());
    drain();
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
    end
  end

  // check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(out_data), 64'd0);
      end else begin
        out_item_t w;
        w = expected_q.pop_front();
        if (out_data.hop_current_out !== w.hop_current_out)
          report("hop_current_out", 64'(out_data.hop_current_out), 64'(w.hop_current_out));
        if (out_data.hop_suggested_out !== w.hop_suggested_out)
          report("hop_suggested_out", 64'(out_data.hop_suggested_out), 64'(w.hop_suggested_out));
        if (out_data.overload_out !== w.overload_out)
          report("overload_out", 64'(out_data.overload_out), 64'(w.overload_out));
        if (out_data.fair_out !== w.fair_out)
          report("fair_out", 64'(out_data.fair_out), 64'(w.fair_out));
        if (out_data.iteration_out !== w.iteration_out)
          report("iteration_out", 64'(out_data.iteration_out), 64'(w.iteration_out));
        if (out_data.replaced !== w.replaced)
          report("replaced", 64'(out_data.replaced), 64'(w.replaced));
      end
    end
  end

  // watchdog: count cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("congestion_feedback_port_stats verification failed");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NPORTS; p++) begin
      rate_m[p] = '0; flows[p] = '0; uncon[p] = '0; total[p] = '0;
      ovl[p] = '0; fair[p] = '0; iter[p] = '0; ticked[p] = 1'b0;
    end
    mult_reg = 8'd1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    random_cfg(1'b0);
    test_random(400, 0, 0);
    write_reg(REG_SENDS, 32'd1);
    hop_bias = 90;
    test_random(350, 86, 0);
    random_cfg(1'b0);
    hop_bias = 20;
    test_random(350, 0, 86);
    random_cfg(1'b1);
    hop_bias = 50;
    test_random(350, 6, 6);
    test_backpressure();
    drain();
    if (errors == 0) $display("congestion_feedback_port_stats verification clean");
    else $display("congestion_feedback_port_stats verification failed");
    $finish;
  end

endmodule
